// ===== hw/rtl/ngga_pkg.sv =====
// shared types, constants and elaboration helpers of the gga sentence parser
package ngga_pkg;

   localparam int CHAR_W   = 8;
   localparam int HDR_W    = 48;
   localparam int LAT_W    = 31;
   localparam int LON_W    = 34;
   localparam int FIX_W    = 4;
   localparam int SAT_W    = 7;
   localparam int DIL_W    = 14;
   localparam int FIELD_W  = 4;
   localparam int CNT_W    = 4;
   localparam int DEG_W    = 10;
   localparam int FIX_V_W  = 7;
   localparam int SAT_V_W  = 10;
   localparam int DIL_V_W  = 17;
   localparam int RM_W     = 6;

   localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2c;
   localparam logic [CHAR_W-1:0] CHAR_POINT  = 8'h2e;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

   localparam logic [HDR_W-1:0] HEADER_RESET = 48'h244750474741;

   localparam logic [FIELD_W-1:0] FIELD_LAT  = 4'd2;
   localparam logic [FIELD_W-1:0] FIELD_LON  = 4'd4;
   localparam logic [FIELD_W-1:0] FIELD_FIX  = 4'd6;
   localparam logic [FIELD_W-1:0] FIELD_SAT  = 4'd7;
   localparam logic [FIELD_W-1:0] FIELD_DIL  = 4'd8;
   localparam logic [FIELD_W-1:0] FIELD_DONE = 4'd8;
   localparam logic [FIELD_W-1:0] FIELD_MAX  = 4'd15;
   localparam logic [CNT_W-1:0]   CNT_MAX    = 4'd15;

   localparam logic [CNT_W-1:0] LAT_DEG_DIGITS = 4'd2;
   localparam logic [CNT_W-1:0] LON_DEG_DIGITS = 4'd3;

   localparam logic [FIX_W-1:0]   FIX_CAP  = 4'd9;
   localparam logic [SAT_W-1:0]   SAT_CAP  = 7'd99;
   localparam logic [DIL_W-1:0]   DIL_CAP  = 14'd9999;
   localparam logic [DIL_V_W-1:0] DIL_UNIT = 17'd100;
   localparam int                 DIL_FRAC_DIGITS = 2;

   localparam logic [LON_W-1:0] DEG_SCALE = 34'd10000000;

   typedef struct packed {
      logic [LAT_W-1:0] latitude_e7;
      logic [LON_W-1:0] longitude_e7;
      logic [FIX_W-1:0] fix_code;
      logic [SAT_W-1:0] satellite_count;
      logic [DIL_W-1:0] dilution_e2;
      logic             parse_ok;
   } ngga_result_type;

   typedef struct packed {
      logic valid;
      logic is_lon;
   } ngga_conv_req_type;

   function automatic longint pow10(int n);
      longint v;
      v = 1;
      for (int i = 0; i < n; i++) begin
         v = v * 10;
      end
      return v;
   endfunction

   // bits of the minutes accumulator, saturating one unit below 660 minutes
   function automatic int min_acc_width(int f);
      return $clog2(660 * pow10(f));
   endfunction

endpackage

// ===== hw/rtl/ngga_conv.sv =====
// coordinate conversion pipeline: degrees and scaled minutes to 1e-7 degree
module ngga_conv #(
   parameter int MINUTE_FRACTION_DIGITS = 4,
   localparam int MIN_W = ngga_pkg::min_acc_width(MINUTE_FRACTION_DIGITS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ngga_pkg::ngga_conv_req_type       conv_req,
   input  logic [ngga_pkg::DEG_W-1:0]        conv_deg,
   input  logic [MIN_W-1:0]                  conv_min,
   output logic [ngga_pkg::LAT_W-1:0]        lat_held,
   output logic [ngga_pkg::LON_W-1:0]        lon_held
);

   localparam int     RS        = MIN_W + 6;
   localparam int     RECIP_W   = MIN_W + 1;
   localparam int     PROD_W    = MIN_W + RECIP_W;
   localparam int     QM_W      = MIN_W - 5;
   localparam longint RECIP     = ((longint'(1) << RS) + 59) / 60;
   localparam longint MIN_SCALE = ngga_pkg::pow10(7 - MINUTE_FRACTION_DIGITS);
   localparam int     A_W       = $clog2(MIN_SCALE);

   // floor(r * MIN_SCALE / 60) for a remainder r of minutes mod 60
   logic [A_W-1:0] frac_tbl [2**ngga_pkg::RM_W];

   for (genvar r = 0; r < 2**ngga_pkg::RM_W; r++) begin : g_frac
      localparam longint FV = (r * MIN_SCALE) / 60;
      assign frac_tbl[r] = A_W'(FV);
   end

   logic                       s1_valid_ff;
   logic                       s1_lon_ff;
   logic [PROD_W-1:0]          s1_prod_ff;
   logic [ngga_pkg::LON_W-1:0] s1_deg_ff;
   logic [MIN_W-1:0]           s1_min_ff;

   logic                       s2_valid_ff;
   logic                       s2_lon_ff;
   logic [QM_W-1:0]            s2_qm_ff;
   logic [ngga_pkg::RM_W-1:0]  s2_rm_ff;
   logic [ngga_pkg::LON_W-1:0] s2_deg_ff;

   logic [ngga_pkg::LAT_W-1:0] lat_held_ff;
   logic [ngga_pkg::LON_W-1:0] lon_held_ff;

   logic [QM_W-1:0]            qm;
   logic [MIN_W-1:0]           rm_full;
   logic [ngga_pkg::LON_W-1:0] coord;

   // quotient by reciprocal is exact over the whole minutes range
   always_comb begin
      qm      = s1_prod_ff[PROD_W-1:RS];
      rm_full = s1_min_ff - MIN_W'({qm, 6'b000000}) + MIN_W'({qm, 2'b00});
      coord   = s2_deg_ff + ngga_pkg::LON_W'(s2_qm_ff) * ngga_pkg::LON_W'(MIN_SCALE)
              + ngga_pkg::LON_W'(frac_tbl[s2_rm_ff]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= conv_req.valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (conv_req.valid) begin
         s1_lon_ff  <= conv_req.is_lon;
         s1_prod_ff <= PROD_W'(conv_min) * PROD_W'(RECIP);
         s1_deg_ff  <= ngga_pkg::LON_W'(conv_deg) * ngga_pkg::DEG_SCALE;
         s1_min_ff  <= conv_min;
      end
      if (s1_valid_ff) begin
         s2_lon_ff <= s1_lon_ff;
         s2_qm_ff  <= qm;
         s2_rm_ff  <= rm_full[ngga_pkg::RM_W-1:0];
         s2_deg_ff <= s1_deg_ff;
      end
      if (s2_valid_ff) begin
         if (s2_lon_ff) begin
            lon_held_ff <= coord;
         end else begin
            lat_held_ff <= ngga_pkg::LAT_W'(coord);
         end
      end
   end

   assign lat_held = lat_held_ff;
   assign lon_held = lon_held_ff;

endmodule

// ===== hw/rtl/ngga_scan.sv =====
// byte scanner: input register, header match, field counting and number parsing
module ngga_scan #(
   parameter int HEADER_LEN = 6,
   parameter int MINUTE_FRACTION_DIGITS = 4,
   localparam int MIN_W = ngga_pkg::min_acc_width(MINUTE_FRACTION_DIGITS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ngga_pkg::CHAR_W-1:0]       req_char_in,
   input  logic                              csr_wr_en,
   input  logic [ngga_pkg::HDR_W-1:0]        csr_wr_data,
   input  logic                              blocked,
   input  logic [ngga_pkg::LAT_W-1:0]        lat_held,
   input  logic [ngga_pkg::LON_W-1:0]        lon_held,
   output ngga_pkg::ngga_result_type         result,
   output logic                              result_valid,
   output ngga_pkg::ngga_conv_req_type       conv_req,
   output logic [ngga_pkg::DEG_W-1:0]        conv_deg,
   output logic [MIN_W-1:0]                  conv_min
);

   localparam int     F       = MINUTE_FRACTION_DIGITS;
   localparam int     HP_W    = $clog2(HEADER_LEN + 1);
   localparam int     FMAX    = (F > ngga_pkg::DIL_FRAC_DIGITS) ? F : ngga_pkg::DIL_FRAC_DIGITS;
   localparam int     FR_W    = $clog2(FMAX + 1);
   localparam int     MV_W    = MIN_W + 4;
   localparam longint MIN_UNIT = ngga_pkg::pow10(F);
   localparam longint MIN_CAP  = 660 * MIN_UNIT - 1;

   logic [MV_W-1:0] pow_tbl [2**FR_W];

   for (genvar k = 0; k < 2**FR_W; k++) begin : g_pow
      localparam longint PV = ngga_pkg::pow10(k);
      assign pow_tbl[k] = MV_W'(PV);
   end

   logic                          in_valid_ff;
   logic [ngga_pkg::CHAR_W-1:0]   in_char_ff;
   logic [ngga_pkg::HDR_W-1:0]    header_ff;
   logic [HP_W-1:0]               hp_ff, hp_in;
   logic                          match_ff, match_in;
   logic [ngga_pkg::FIELD_W-1:0]  field_ff, field_in;
   logic [ngga_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                          stop_ff, stop_in;
   logic                          point_ff, point_in;
   logic [FR_W-1:0]               frac_ff, frac_in;
   logic [ngga_pkg::DEG_W-1:0]    deg_ff, deg_in;
   logic [MIN_W-1:0]              min_ff, min_in;
   logic [ngga_pkg::FIX_W-1:0]    fix_ff, fix_in;
   logic [ngga_pkg::SAT_W-1:0]    sat_ff, sat_in;
   logic [ngga_pkg::DIL_W-1:0]    dil_ff, dil_in;

   logic                          step;
   logic                          emit;
   logic                          ok;
   logic                          go;
   logic                          dig;
   logic                          upd;
   logic [3:0]                    dval;
   logic [63:0]                   hdr_ext;
   logic [2:0]                    hidx;
   logic [ngga_pkg::CHAR_W-1:0]   hbyte;
   logic [ngga_pkg::CNT_W-1:0]    dd;
   logic [MV_W-1:0]               mv;
   logic [ngga_pkg::DIL_V_W-1:0]  dv;
   logic [ngga_pkg::FIX_V_W-1:0]  fv;
   logic [ngga_pkg::SAT_V_W-1:0]  sv;

   assign step      = in_valid_ff && !blocked;
   assign req_stall = blocked;
   assign hdr_ext   = {16'h0000, header_ff};
   assign dig       = (in_char_ff >= ngga_pkg::CHAR_ZERO) && (in_char_ff <= ngga_pkg::CHAR_NINE);
   assign dval      = in_char_ff[3:0];

   always_comb begin
      hp_in    = hp_ff;
      match_in = match_ff;
      field_in = field_ff;
      cnt_in   = cnt_ff;
      stop_in  = stop_ff;
      point_in = point_ff;
      frac_in  = frac_ff;
      deg_in   = deg_ff;
      min_in   = min_ff;
      fix_in   = fix_ff;
      sat_in   = sat_ff;
      dil_in   = dil_ff;
      emit     = 1'b0;
      go       = 1'b0;
      upd      = 1'b0;
      hidx     = '0;
      hbyte    = '0;
      dd       = ngga_pkg::LAT_DEG_DIGITS;
      mv       = '0;
      dv       = '0;
      fv       = '0;
      sv       = '0;
      conv_req = '0;
      if (step) begin
         emit = (in_char_ff == ngga_pkg::CHAR_DOLLAR) && match_ff
             && (hp_ff == HP_W'(HEADER_LEN));
         // a dollar sign opens a new sentence whatever came before
         if (in_char_ff == ngga_pkg::CHAR_DOLLAR) begin
            hp_in    = '0;
            match_in = 1'b1;
            field_in = '0;
            cnt_in   = '0;
            stop_in  = 1'b0;
            point_in = 1'b0;
            frac_in  = '0;
            deg_in   = '0;
            min_in   = '0;
            fix_in   = '0;
            sat_in   = '0;
            dil_in   = '0;
         end
         go = match_in;
         if (go && (hp_in < HP_W'(HEADER_LEN))) begin
            hidx  = 3'(HEADER_LEN - 1) - 3'(hp_in);
            hbyte = hdr_ext[{hidx, 3'b000} +: 8];
            if (in_char_ff != hbyte) begin
               match_in = 1'b0;
               go       = 1'b0;
            end else begin
               hp_in = hp_in + 1'b1;
            end
         end
         if (go && (in_char_ff == ngga_pkg::CHAR_COMMA)) begin
            conv_req.valid  = (field_in == ngga_pkg::FIELD_LAT)
                           || (field_in == ngga_pkg::FIELD_LON);
            conv_req.is_lon = (field_in == ngga_pkg::FIELD_LON);
            if (field_in != ngga_pkg::FIELD_MAX) begin
               field_in = field_in + 1'b1;
            end
            cnt_in   = '0;
            stop_in  = 1'b0;
            point_in = 1'b0;
            frac_in  = '0;
            deg_in   = '0;
            min_in   = '0;
            go       = 1'b0;
         end
         if (go) begin
            unique case (field_in)
               ngga_pkg::FIELD_LAT, ngga_pkg::FIELD_LON: begin
                  dd = (field_in == ngga_pkg::FIELD_LON) ? ngga_pkg::LON_DEG_DIGITS
                                                         : ngga_pkg::LAT_DEG_DIGITS;
                  if (cnt_in < dd) begin
                     if (!stop_in && dig) begin
                        deg_in = ngga_pkg::DEG_W'(deg_in * ngga_pkg::DEG_W'(10))
                               + ngga_pkg::DEG_W'(dval);
                     end else begin
                        stop_in = 1'b1;
                     end
                  end else begin
                     // minutes start right after the degree characters
                     if (cnt_in == dd) begin
                        stop_in = 1'b0;
                     end
                     if (!stop_in) begin
                        if (dig) begin
                           if (!point_in) begin
                              mv  = MV_W'(min_in) * MV_W'(10)
                                  + MV_W'(dval) * MV_W'(MIN_UNIT);
                              upd = 1'b1;
                           end else if (frac_in < FR_W'(F)) begin
                              frac_in = frac_in + 1'b1;
                              mv  = MV_W'(min_in)
                                  + MV_W'(dval) * pow_tbl[FR_W'(F) - frac_in];
                              upd = 1'b1;
                           end
                           if (upd) begin
                              min_in = (mv > MV_W'(MIN_CAP)) ? MIN_W'(MIN_CAP)
                                                             : MIN_W'(mv);
                           end
                        end else if ((in_char_ff == ngga_pkg::CHAR_POINT) && !point_in) begin
                           point_in = 1'b1;
                        end else begin
                           stop_in = 1'b1;
                        end
                     end
                  end
               end
               ngga_pkg::FIELD_FIX: begin
                  if (!stop_in) begin
                     if (dig) begin
                        fv = ngga_pkg::FIX_V_W'(fix_in) * ngga_pkg::FIX_V_W'(10)
                           + ngga_pkg::FIX_V_W'(dval);
                        fix_in = (fv > ngga_pkg::FIX_V_W'(ngga_pkg::FIX_CAP))
                               ? ngga_pkg::FIX_CAP : ngga_pkg::FIX_W'(fv);
                     end else begin
                        stop_in = 1'b1;
                     end
                  end
               end
               ngga_pkg::FIELD_SAT: begin
                  if (!stop_in) begin
                     if (dig) begin
                        sv = ngga_pkg::SAT_V_W'(sat_in) * ngga_pkg::SAT_V_W'(10)
                           + ngga_pkg::SAT_V_W'(dval);
                        sat_in = (sv > ngga_pkg::SAT_V_W'(ngga_pkg::SAT_CAP))
                               ? ngga_pkg::SAT_CAP : ngga_pkg::SAT_W'(sv);
                     end else begin
                        stop_in = 1'b1;
                     end
                  end
               end
               ngga_pkg::FIELD_DIL: begin
                  if (!stop_in) begin
                     if (dig) begin
                        if (!point_in) begin
                           dv  = ngga_pkg::DIL_V_W'(dil_in) * ngga_pkg::DIL_V_W'(10)
                               + ngga_pkg::DIL_V_W'(dval) * ngga_pkg::DIL_UNIT;
                           upd = 1'b1;
                        end else if (frac_in < FR_W'(ngga_pkg::DIL_FRAC_DIGITS)) begin
                           frac_in = frac_in + 1'b1;
                           dv  = ngga_pkg::DIL_V_W'(dil_in) + ngga_pkg::DIL_V_W'(dval)
                               * ngga_pkg::DIL_V_W'(
                                    pow_tbl[FR_W'(ngga_pkg::DIL_FRAC_DIGITS) - frac_in]);
                           upd = 1'b1;
                        end
                        if (upd) begin
                           dil_in = (dv > ngga_pkg::DIL_V_W'(ngga_pkg::DIL_CAP))
                                  ? ngga_pkg::DIL_CAP : ngga_pkg::DIL_W'(dv);
                        end
                     end else if ((in_char_ff == ngga_pkg::CHAR_POINT) && !point_in) begin
                        point_in = 1'b1;
                     end else begin
                        stop_in = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
            if (cnt_in != ngga_pkg::CNT_MAX) begin
               cnt_in = cnt_in + 1'b1;
            end
         end
      end
   end

   // result from the state before the closing dollar sign
   always_comb begin
      ok                     = (field_ff >= ngga_pkg::FIELD_DONE);
      result_valid           = emit;
      result.latitude_e7     = ok ? lat_held : '0;
      result.longitude_e7    = ok ? lon_held : '0;
      result.fix_code        = ok ? fix_ff : '0;
      result.satellite_count = ok ? sat_ff : '0;
      result.dilution_e2     = (ok && (fix_ff != '0)) ? dil_ff : '0;
      result.parse_ok        = ok;
   end

   assign conv_deg = deg_ff;
   assign conv_min = min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         header_ff   <= ngga_pkg::HEADER_RESET;
         hp_ff       <= '0;
         match_ff    <= 1'b0;
         field_ff    <= '0;
         cnt_ff      <= '0;
         stop_ff     <= 1'b0;
         point_ff    <= 1'b0;
         frac_ff     <= '0;
      end else begin
         if (!blocked) begin
            in_valid_ff <= req_valid;
         end
         if (csr_wr_en) begin
            header_ff <= csr_wr_data;
         end
         if (step) begin
            hp_ff    <= hp_in;
            match_ff <= match_in;
            field_ff <= field_in;
            cnt_ff   <= cnt_in;
            stop_ff  <= stop_in;
            point_ff <= point_in;
            frac_ff  <= frac_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !blocked) begin
         in_char_ff <= req_char_in;
      end
      if (step) begin
         deg_ff <= deg_in;
         min_ff <= min_in;
         fix_ff <= fix_in;
         sat_ff <= sat_in;
         dil_ff <= dil_in;
      end
   end

endmodule

// ===== hw/rtl/ngga_obuf.sv =====
// result register with one skid entry behind it
module ngga_obuf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  ngga_pkg::ngga_result_type in_result,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output ngga_pkg::ngga_result_type rsp_result,
   output logic                      blocked
);

   logic                      rsp_valid_ff;
   logic                      skid_valid_ff;
   ngga_pkg::ngga_result_type rsp_ff;
   ngga_pkg::ngga_result_type skid_ff;
   logic                      rsp_free;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign blocked    = skid_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_free) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (in_valid) begin
         if (rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_free) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_free) begin
            rsp_ff <= skid_ff;
         end
      end else if (in_valid) begin
         if (rsp_free) begin
            rsp_ff <= in_result;
         end else begin
            skid_ff <= in_result;
         end
      end
   end

endmodule

// ===== hw/rtl/nmea_gga_position_parser.sv =====
// GGA position parser: takes one stream byte per clock and reports one fix per
// matching sentence; the input stalls only when the result register and its
// skid entry both hold a result that has not been taken. The closing dollar
// sign is registered, then its result in the output buffer. Latitude and
// longitude are converted in a three-stage pipeline started by the comma
// ending the coordinate field, which always finishes before the sentence can
// close with all fields present. The user must write the header register only
// while no byte is in flight; the block itself does not enforce this.
module nmea_gga_position_parser #(
   parameter int HEADER_LEN = 6,
   parameter int MINUTE_FRACTION_DIGITS = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ngga_pkg::CHAR_W-1:0]  req_char_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ngga_pkg::LAT_W-1:0]   rsp_latitude_e7,
   output logic [ngga_pkg::LON_W-1:0]   rsp_longitude_e7,
   output logic [ngga_pkg::FIX_W-1:0]   rsp_fix_code,
   output logic [ngga_pkg::SAT_W-1:0]   rsp_satellite_count,
   output logic [ngga_pkg::DIL_W-1:0]   rsp_dilution_e2,
   output logic                         rsp_parse_ok,
   input  logic                         csr_wr_en,
   input  logic [ngga_pkg::HDR_W-1:0]   csr_wr_data
);

   localparam int MIN_W = ngga_pkg::min_acc_width(MINUTE_FRACTION_DIGITS);

   logic                         blocked;
   logic                         result_valid;
   ngga_pkg::ngga_result_type    result;
   ngga_pkg::ngga_result_type    rsp_result;
   ngga_pkg::ngga_conv_req_type  conv_req;
   logic [ngga_pkg::DEG_W-1:0]   conv_deg;
   logic [MIN_W-1:0]             conv_min;
   logic [ngga_pkg::LAT_W-1:0]   lat_held;
   logic [ngga_pkg::LON_W-1:0]   lon_held;

   ngga_scan #(
      .HEADER_LEN             (HEADER_LEN),
      .MINUTE_FRACTION_DIGITS (MINUTE_FRACTION_DIGITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_char_in  (req_char_in),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .blocked      (blocked),
      .lat_held     (lat_held),
      .lon_held     (lon_held),
      .result       (result),
      .result_valid (result_valid),
      .conv_req     (conv_req),
      .conv_deg     (conv_deg),
      .conv_min     (conv_min)
   );

   ngga_conv #(
      .MINUTE_FRACTION_DIGITS (MINUTE_FRACTION_DIGITS)
   ) u_conv (
      .clock    (clock),
      .reset    (reset),
      .conv_req (conv_req),
      .conv_deg (conv_deg),
      .conv_min (conv_min),
      .lat_held (lat_held),
      .lon_held (lon_held)
   );

   ngga_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (result_valid),
      .in_result  (result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .blocked    (blocked)
   );

   assign rsp_latitude_e7     = rsp_result.latitude_e7;
   assign rsp_longitude_e7    = rsp_result.longitude_e7;
   assign rsp_fix_code        = rsp_result.fix_code;
   assign rsp_satellite_count = rsp_result.satellite_count;
   assign rsp_dilution_e2     = rsp_result.dilution_e2;
   assign rsp_parse_ok        = rsp_result.parse_ok;

endmodule
